// ===== rtl/core/mlp_pkg.sv =====
// Shared types, constants and the exponential table for the MLP inference block.
// Used by mlp_ctrl, mlp_datapath and mlp_forward_inference_top; no dependencies.
`default_nettype none

package mlp_pkg;

  localparam int MAX_LAYERS  = 4;
  localparam int MAX_NEURONS = 16;
  localparam int VALUE_W     = 16;
  localparam int FINAL_W     = 24;
  localparam int ACC_W       = 38;
  localparam int TOTAL_W     = 21;
  localparam int DIST_W      = FINAL_W + 1;
  localparam int DIV_W       = 38;
  localparam int EXP_DEPTH   = 256;
  localparam int EXP_IDX_W   = $clog2(EXP_DEPTH);
  localparam int LAYER_W     = $clog2(MAX_LAYERS);
  localparam int NEURON_W    = $clog2(MAX_NEURONS);
  localparam int COUNT_W     = NEURON_W + 1;
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4162825044;

  // Item function codes
  localparam logic [1:0] FUNC_WEIGHT = 2'd0;
  localparam logic [1:0] FUNC_BIAS   = 2'd1;
  localparam logic [1:0] FUNC_INPUT  = 2'd2;
  localparam logic [1:0] FUNC_RUN    = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
  localparam logic [2:0] REG_INPUT_COUNT = 3'd1;
  localparam logic [2:0] REG_HIDDEN_0    = 3'd2;
  localparam logic [2:0] REG_HIDDEN_1    = 3'd3;
  localparam logic [2:0] REG_HIDDEN_2    = 3'd4;
  localparam logic [2:0] REG_OUTPUT_CNT  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH,
    ST_SM_RD,
    ST_SM_EXP,
    ST_SIG_RD,
    ST_SIG_EXP,
    ST_DIV_RD,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_EMIT
  } state_t;

  // Clamped layer geometry
  typedef struct packed {
    logic [2:0]         layers;
    logic [COUNT_W-1:0] n_in;
    logic [COUNT_W-1:0] hid0;
    logic [COUNT_W-1:0] hid1;
    logic [COUNT_W-1:0] hid2;
    logic [COUNT_W-1:0] n_out;
  } counts_t;

  typedef struct packed {
    logic                mac_issue;
    logic                acc_clear;
    logic                finish;
    logic                is_last;
    logic [LAYER_W-1:0]  layer;
    logic [NEURON_W-1:0] neuron;
    logic [NEURON_W-1:0] source;
    logic                fin_rd;
    logic                total_clear;
    logic                soft_exp;
    logic                sig_exp;
    logic                exp_rd;
    logic                div_start;
    logic                sigmoid;
    logic                out_load;
    logic                out_last;
    logic [NEURON_W-1:0] index;
  } cmd_t;

  typedef struct packed {
    logic mac_empty;
    logic div_busy;
    logic out_free;
  } status_t;

  typedef logic [15:0] exp_table_t [EXP_DEPTH];

  // exp(-k/32) in Q0.16, built by repeated multiplication at elaboration
  function automatic exp_table_t build_exp_table();
    logic [63:0] v;
    logic [63:0] e;
    exp_table_t  t;
    v = 64'h1_0000_0000;
    for (int k = 0; k < EXP_DEPTH; k++) begin
      e = (v + 64'd32768) >> 16;
      t[k] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
      v = (v * EXP_STEP_Q32) >> 32;
    end
    return t;
  endfunction

  localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

`default_nettype wire

// ===== rtl/core/mlp_ctrl.sv =====
// Sequencer for the MLP block: walks layers, neurons and sources, then the
// softmax or sigmoid passes and the divisions. Depends on mlp_pkg.
`default_nettype none

module mlp_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [1:0]      func,
  input  mlp_pkg::counts_t     counts,
  input  mlp_pkg::status_t     status,
  output logic                 in_ready,
  output mlp_pkg::cmd_t        cmd
);

  mlp_pkg::state_t state, state_next;
  logic [mlp_pkg::LAYER_W-1:0]  l, l_next;
  logic [mlp_pkg::NEURON_W-1:0] j, j_next;
  logic [mlp_pkg::NEURON_W-1:0] s, s_next;
  logic [mlp_pkg::NEURON_W-1:0] k, k_next;
  logic [mlp_pkg::COUNT_W-1:0]  n_src, n_src_next;
  logic [mlp_pkg::COUNT_W-1:0]  n_hid;
  logic [mlp_pkg::COUNT_W-1:0]  n_cur;
  logic                         is_last;
  logic                         sigmoid;

  // Geometry of the current layer
  always_comb begin
    case (l)
      2'd0:    n_hid = counts.hid0;
      2'd1:    n_hid = counts.hid1;
      default: n_hid = counts.hid2;
    endcase
    is_last = ({1'b0, l} == counts.layers - 3'd1);
    n_cur   = is_last ? counts.n_out : n_hid;
    sigmoid = (counts.n_out == mlp_pkg::COUNT_W'(1));
  end

  // Hold state and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlp_pkg::ST_IDLE;
      l     <= '0;
      j     <= '0;
      s     <= '0;
      k     <= '0;
      n_src <= '0;
    end else begin
      state <= state_next;
      l     <= l_next;
      j     <= j_next;
      s     <= s_next;
      k     <= k_next;
      n_src <= n_src_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    l_next      = l;
    j_next      = j;
    s_next      = s;
    k_next      = k;
    n_src_next  = n_src;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.layer   = l;
    cmd.neuron  = j;
    cmd.source  = s;
    cmd.index   = k;
    cmd.is_last = is_last;
    cmd.sigmoid = sigmoid;
    case (state)
      mlp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && func == mlp_pkg::FUNC_RUN) begin
          l_next     = '0;
          j_next     = '0;
          s_next     = '0;
          n_src_next = counts.n_in;
          state_next = mlp_pkg::ST_MAC;
        end
      end
      mlp_pkg::ST_MAC: begin
        cmd.mac_issue = 1'b1;
        cmd.acc_clear = (s == '0);
        if ({1'b0, s} == n_src - mlp_pkg::COUNT_W'(1)) begin
          state_next = mlp_pkg::ST_DRAIN;
        end else begin
          s_next = s + 1'b1;
        end
      end
      mlp_pkg::ST_DRAIN: begin
        if (status.mac_empty) begin
          state_next = mlp_pkg::ST_FINISH;
        end
      end
      mlp_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        s_next     = '0;
        if ({1'b0, j} == n_cur - mlp_pkg::COUNT_W'(1)) begin
          j_next = '0;
          k_next = '0;
          if (is_last) begin
            state_next = sigmoid ? mlp_pkg::ST_SIG_RD : mlp_pkg::ST_SM_RD;
          end else begin
            l_next     = l + 1'b1;
            n_src_next = n_cur;
            state_next = mlp_pkg::ST_MAC;
          end
        end else begin
          j_next     = j + 1'b1;
          state_next = mlp_pkg::ST_MAC;
        end
      end
      mlp_pkg::ST_SM_RD: begin
        cmd.fin_rd      = 1'b1;
        cmd.total_clear = (k == '0);
        state_next      = mlp_pkg::ST_SM_EXP;
      end
      mlp_pkg::ST_SM_EXP: begin
        cmd.soft_exp = 1'b1;
        if ({1'b0, k} == counts.n_out - mlp_pkg::COUNT_W'(1)) begin
          k_next     = '0;
          state_next = mlp_pkg::ST_DIV_RD;
        end else begin
          k_next     = k + 1'b1;
          state_next = mlp_pkg::ST_SM_RD;
        end
      end
      mlp_pkg::ST_SIG_RD: begin
        cmd.fin_rd = 1'b1;
        state_next = mlp_pkg::ST_SIG_EXP;
      end
      mlp_pkg::ST_SIG_EXP: begin
        cmd.sig_exp = 1'b1;
        k_next      = '0;
        state_next  = mlp_pkg::ST_DIV_RD;
      end
      mlp_pkg::ST_DIV_RD: begin
        cmd.exp_rd = 1'b1;
        state_next = mlp_pkg::ST_DIV_START;
      end
      mlp_pkg::ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = mlp_pkg::ST_DIV_RUN;
      end
      mlp_pkg::ST_DIV_RUN: begin
        if (!status.div_busy) begin
          state_next = mlp_pkg::ST_EMIT;
        end
      end
      mlp_pkg::ST_EMIT: begin
        cmd.out_last = ({1'b0, k} == counts.n_out - mlp_pkg::COUNT_W'(1));
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (cmd.out_last) begin
            state_next = mlp_pkg::ST_IDLE;
          end else begin
            k_next     = k + 1'b1;
            state_next = mlp_pkg::ST_DIV_RD;
          end
        end
      end
      default: begin
        state_next = mlp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/mlp_datapath.sv =====
// Datapath for the MLP block: stores, multiply-accumulate pipeline, exponential
// lookup, restoring divider and output register. Depends on mlp_pkg.
`default_nettype none

module mlp_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load_en,
  input  wire logic [1:0]                    func,
  input  wire logic [mlp_pkg::LAYER_W-1:0]   layer_sel,
  input  wire logic [mlp_pkg::NEURON_W-1:0]  neuron_sel,
  input  wire logic [mlp_pkg::NEURON_W-1:0]  source_sel,
  input  wire logic signed [mlp_pkg::VALUE_W-1:0] value,
  input  mlp_pkg::cmd_t                      cmd,
  output mlp_pkg::status_t                   status,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mlp_pkg::NEURON_W-1:0]       out_index,
  output logic [15:0]                        probability,
  output logic                               last
);

  localparam int W_DEPTH = mlp_pkg::MAX_LAYERS * mlp_pkg::MAX_NEURONS * mlp_pkg::MAX_NEURONS;
  localparam int B_DEPTH = mlp_pkg::MAX_LAYERS * mlp_pkg::MAX_NEURONS;
  localparam int A_DEPTH = 2 * mlp_pkg::MAX_NEURONS;
  localparam int VW      = mlp_pkg::VALUE_W;
  localparam int FW      = mlp_pkg::FINAL_W;
  localparam int AW      = mlp_pkg::ACC_W;
  localparam int TW      = mlp_pkg::TOTAL_W;
  localparam int DW      = mlp_pkg::DIST_W;
  localparam int XW      = mlp_pkg::DIV_W;
  localparam int CNT_W   = $clog2(XW + 1);
  localparam logic signed [AW-1:0] FIN_HI = AW'(2 ** (FW - 1) - 1);
  localparam logic signed [AW-1:0] FIN_LO = -FIN_HI - AW'(1);
  localparam logic signed [AW-1:0] VAL_HI = AW'(2 ** (VW - 1) - 1);
  localparam logic signed [AW-1:0] VAL_LO = -VAL_HI - AW'(1);

  logic [VW-1:0] wmem [W_DEPTH];
  logic [VW-1:0] bmem [B_DEPTH];
  logic [VW-1:0] imem [mlp_pkg::MAX_NEURONS];
  logic [VW-1:0] amem [A_DEPTH];
  logic [FW-1:0] fmem [mlp_pkg::MAX_NEURONS];
  logic [15:0]   emem [mlp_pkg::MAX_NEURONS];

  logic signed [VW-1:0]   w_q, x_q, b_q;
  logic signed [2*VW-1:0] prod;
  logic signed [AW-1:0]   acc;
  logic                   v1, v2;
  logic signed [AW-1:0]   sum, shifted;
  logic signed [FW-1:0]   fin_sat;
  logic signed [VW-1:0]   hid_sat;
  logic signed [FW-1:0]   max_q, fin_q;
  logic [DW-1:0]          spread, mag;
  logic [15:0]            e_soft, e_sig, exp_q;
  logic [TW-1:0]          total;
  logic                   sig_neg;
  logic [XW-1:0]          dvd, quot;
  logic [TW-1:0]          rem;
  logic [TW:0]            rem_sh;
  logic [CNT_W-1:0]       div_cnt;
  logic                   div_busy;

  function automatic logic [15:0] exp_lookup(input logic [DW-1:0] d);
    logic [15:0] r;
    r = '0;
    if (d[DW-1:mlp_pkg::EXP_IDX_W+3] == '0) begin
      r = mlp_pkg::EXP_TABLE[d[mlp_pkg::EXP_IDX_W+2:3]];
    end
    return r;
  endfunction

  // Load items write one entry of a store
  always_ff @(posedge clk) begin
    if (load_en && func == mlp_pkg::FUNC_WEIGHT) begin
      wmem[{layer_sel, neuron_sel, source_sel}] <= value;
    end
    if (load_en && func == mlp_pkg::FUNC_BIAS) begin
      bmem[{layer_sel, neuron_sel}] <= value;
    end
    if (load_en && func == mlp_pkg::FUNC_INPUT) begin
      imem[neuron_sel] <= value;
    end
  end

  // Fetch weight, source and bias
  always_ff @(posedge clk) begin
    b_q <= bmem[{cmd.layer, cmd.neuron}];
    if (cmd.mac_issue) begin
      w_q <= wmem[{cmd.layer, cmd.neuron, cmd.source}];
      x_q <= (cmd.layer == '0) ? imem[cmd.source] : amem[{~cmd.layer[0], cmd.source}];
    end
  end

  // Multiply, then accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.mac_issue;
      v2 <= v1;
    end
    if (v1) begin
      prod <= w_q * x_q;
    end
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + AW'(prod);
    end
  end

  // Add bias, floor shift and saturate
  always_comb begin
    sum     = acc + {{(AW-VW-8){b_q[VW-1]}}, b_q, 8'd0};
    shifted = sum >>> 8;
    if (shifted > FIN_HI)      fin_sat = FIN_HI[FW-1:0];
    else if (shifted < FIN_LO) fin_sat = FIN_LO[FW-1:0];
    else                       fin_sat = shifted[FW-1:0];
    if (shifted > VAL_HI)      hid_sat = VAL_HI[VW-1:0];
    else if (shifted < VAL_LO) hid_sat = VAL_LO[VW-1:0];
    else                       hid_sat = shifted[VW-1:0];
  end

  // Write the neuron result; track the maximum of the last layer
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (cmd.is_last) begin
        fmem[cmd.neuron] <= fin_sat;
        if (cmd.neuron == '0 || fin_sat > max_q) begin
          max_q <= fin_sat;
        end
      end else begin
        amem[{cmd.layer[0], cmd.neuron}] <= (hid_sat > 0) ? hid_sat : '0;
      end
    end
  end

  // Exponentials for softmax and sigmoid
  always_comb begin
    spread = DW'({max_q[FW-1], max_q}) - DW'({fin_q[FW-1], fin_q});
    mag    = fin_q[FW-1] ? DW'(-{fin_q[FW-1], fin_q}) : DW'({1'b0, fin_q});
    e_soft = exp_lookup(spread);
    e_sig  = exp_lookup(mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (cmd.total_clear) begin
      total <= '0;
    end else if (cmd.soft_exp) begin
      total <= total + TW'(e_soft);
    end else if (cmd.sig_exp) begin
      total <= TW'(17'h10000) + TW'(e_sig);
    end
    if (cmd.fin_rd) begin
      fin_q <= fmem[cmd.index];
    end
    if (cmd.soft_exp) begin
      emem[cmd.index] <= e_soft;
    end
    if (cmd.sig_exp) begin
      emem[cmd.index] <= e_sig;
      sig_neg         <= fin_q[FW-1];
    end
    if (cmd.exp_rd) begin
      exp_q <= emem[cmd.index];
    end
  end

  // Restoring divider, one quotient bit a cycle
  assign rem_sh = {rem, dvd[XW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
      div_cnt  <= CNT_W'(XW);
    end else if (div_busy) begin
      div_cnt <= div_cnt - 1'b1;
      if (div_cnt == CNT_W'(1)) begin
        div_busy <= 1'b0;
      end
    end
    if (cmd.div_start) begin
      rem  <= '0;
      quot <= '0;
      if (!cmd.sigmoid) begin
        dvd <= XW'({exp_q, 16'd0}) + XW'(total >> 1);
      end else if (sig_neg) begin
        dvd <= XW'({exp_q, 16'd0});
      end else begin
        dvd <= XW'(33'h1_0000_0000);
      end
    end else if (div_busy) begin
      dvd <= dvd << 1;
      if (rem_sh >= {1'b0, total}) begin
        rem  <= TW'(rem_sh - {1'b0, total});
        quot <= {quot[XW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[TW-1:0];
        quot <= {quot[XW-2:0], 1'b0};
      end
    end
  end

  // Output register; hold until transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_index   <= cmd.index;
      probability <= (quot > XW'(65535)) ? 16'hFFFF : quot[15:0];
      last        <= cmd.out_last;
    end
  end

  always_comb begin
    status.mac_empty = !v1 && !v2;
    status.div_busy  = div_busy;
    status.out_free  = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// ===== rtl/core/mlp_forward_inference_top.sv =====
// Top level of the MLP inference block: configuration registers, sequencer
// and datapath. Depends on mlp_pkg, mlp_ctrl and mlp_datapath.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_ready    func, layer_sel, neuron_sel, source_sel, value
//   out       source     out_valid / out_ready  out_index, probability, last
//   cfg       sink       cfg_we (no wait)       cfg_index, cfg_data
//
// A load item writes one store entry. A run walks every layer through the
// single multiply-accumulate unit, then computes the exponentials (softmax,
// or sigmoid for a single output) and feeds each output through the
// one-bit-a-cycle divider.
// Reset is synchronous; stores hold nothing defined until written.
// A stalled output holds the sequencer before the next division.
`default_nettype none

module mlp_forward_inference_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [1:0]  layer_sel,
  input  wire logic [3:0]  neuron_sel,
  input  wire logic [3:0]  source_sel,
  input  wire logic signed [15:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_index,
  output logic [15:0]      probability,
  output logic             last,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);

  logic [2:0] layer_count;
  logic [4:0] input_count, hidden_width_0, hidden_width_1, hidden_width_2, output_count;
  mlp_pkg::counts_t counts;
  mlp_pkg::cmd_t    cmd;
  mlp_pkg::status_t status;

  function automatic logic [4:0] clamp_count(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (v == 5'd0)       r = 5'd1;
    else if (v > 5'd16)  r = 5'd16;
    return r;
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count    <= 3'd1;
      input_count    <= 5'd16;
      hidden_width_0 <= 5'd16;
      hidden_width_1 <= 5'd16;
      hidden_width_2 <= 5'd16;
      output_count   <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        mlp_pkg::REG_LAYER_COUNT: layer_count    <= cfg_data[2:0];
        mlp_pkg::REG_INPUT_COUNT: input_count    <= cfg_data;
        mlp_pkg::REG_HIDDEN_0:    hidden_width_0 <= cfg_data;
        mlp_pkg::REG_HIDDEN_1:    hidden_width_1 <= cfg_data;
        mlp_pkg::REG_HIDDEN_2:    hidden_width_2 <= cfg_data;
        mlp_pkg::REG_OUTPUT_CNT:  output_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp counts into their working ranges
  always_comb begin
    if (layer_count == 3'd0)      counts.layers = 3'd1;
    else if (layer_count > 3'd4)  counts.layers = 3'd4;
    else                          counts.layers = layer_count;
    counts.n_in  = clamp_count(input_count);
    counts.hid0  = clamp_count(hidden_width_0);
    counts.hid1  = clamp_count(hidden_width_1);
    counts.hid2  = clamp_count(hidden_width_2);
    counts.n_out = clamp_count(output_count);
  end

  mlp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .counts   (counts),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  mlp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .load_en     (in_valid && in_ready),
    .func        (func),
    .layer_sel   (layer_sel),
    .neuron_sel  (neuron_sel),
    .source_sel  (source_sel),
    .value       (value),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_index   (out_index),
    .probability (probability),
    .last        (last)
  );

endmodule

`default_nettype wire

// ===== tb/sv/mlp_forward_inference_top_test.sv =====
// Self-checking testbench for mlp_forward_inference_top: directed table, then random phases.
// Depends on mlp_pkg and the RTL under rtl/core; expected results come from a local predictor.
`timescale 1ns / 1ps

module mlp_forward_inference_top_test;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 60;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 38;

  typedef struct packed {
    logic [3:0]  idx;
    logic [15:0] prob;
    logic        last;
  } prob_t;

  typedef struct {
    logic [1:0]  fn;
    logic [1:0]  lay;
    logic [3:0]  neu;
    logic [3:0]  src;
    logic [15:0] val;
    int          prob;   // typed-in sigmoid result, -1 when the predictor decides
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = '0;
  logic [1:0] layer_sel = '0;
  logic [3:0] neuron_sel = '0;
  logic [3:0] source_sel = '0;
  logic signed [15:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] out_index;
  logic [15:0] probability;
  logic last;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;

  // local copy of stores, registers and the exponential table
  logic [15:0] weights [mlp_pkg::MAX_LAYERS][mlp_pkg::MAX_NEURONS][mlp_pkg::MAX_NEURONS];
  logic [15:0] biases [mlp_pkg::MAX_LAYERS][mlp_pkg::MAX_NEURONS];
  logic [15:0] inputs [mlp_pkg::MAX_NEURONS];
  logic [4:0]  regs [6];
  longint      exp_lut [mlp_pkg::EXP_DEPTH];
  prob_t       pending_probs [$];
  int          fails = 0;
  int          cycles = 0;
  bit          burst = 0;
  row_t        rows [$];

  mlp_forward_inference_top dut (
    .clk, .rst, .in_valid, .in_ready, .func, .layer_sel, .neuron_sel, .source_sel,
    .value, .out_valid, .out_ready, .out_index, .probability, .last,
    .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // abandon the run at the cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int clamp_count(logic [4:0] c, int hi);
    if (c == 0) return 1;
    if (c > hi) return hi;
    return c;
  endfunction

  function automatic longint exp_of(longint d);
    return ((d >> 3) < mlp_pkg::EXP_DEPTH) ? exp_lut[d >> 3] : 0;
  endfunction

  function automatic longint sat(longint x, int bits);
    longint hi;
    hi = (longint'(1) << (bits - 1)) - 1;
    return x > hi ? hi : (x < -hi - 1 ? -hi - 1 : x);
  endfunction

  // evaluate the network and queue one probability per output neuron
  function automatic void predict_probabilities();
    longint srcv [mlp_pkg::MAX_NEURONS];
    longint fsum [mlp_pkg::MAX_NEURONS];
    longint ev [mlp_pkg::MAX_NEURONS];
    longint acc, mx, total, p, u, e;
    int layers, n_out, n_src, n;
    prob_t r;
    layers = clamp_count({2'b0, regs[0][2:0]}, 4);
    n_out  = clamp_count(regs[5], 16);
    n_src  = clamp_count(regs[1], 16);
    for (int s = 0; s < mlp_pkg::MAX_NEURONS; s++) srcv[s] = longint'($signed(inputs[s]));
    for (int l = 0; l < layers; l++) begin
      n = (l == layers - 1) ? n_out : clamp_count(regs[2 + l], 16);
      for (int j = 0; j < n; j++) begin
        acc = longint'($signed(biases[l][j])) * 256;
        for (int s = 0; s < n_src; s++)
          acc += longint'($signed(weights[l][j][s])) * srcv[s];
        acc = acc >>> 8;
        if (l == layers - 1) fsum[j] = sat(acc, mlp_pkg::FINAL_W);
        else begin
          acc = sat(acc, mlp_pkg::VALUE_W);
          ev[j] = acc > 0 ? acc : 0;
        end
      end
      if (l != layers - 1) begin
        for (int s = 0; s < n; s++) srcv[s] = ev[s];
        n_src = n;
      end
    end
    if (n_out > 1) begin
      mx = fsum[0];
      for (int k = 1; k < n_out; k++) if (fsum[k] > mx) mx = fsum[k];
      total = 0;
      for (int k = 0; k < n_out; k++) begin
        ev[k] = exp_of(mx - fsum[k]);
        total += ev[k];
      end
      for (int k = 0; k < n_out; k++) begin
        p = (ev[k] * 65536 + total / 2) / total;
        r.idx = 4'(k);
        r.prob = p > 65535 ? 16'hFFFF : p[15:0];
        r.last = (k == n_out - 1);
        pending_probs.push_back(r);
      end
    end else begin
      u = fsum[0];
      e = exp_of(u < 0 ? -u : u);
      p = (u >= 0) ? ((longint'(1) << 32) / (65536 + e)) : ((e * 65536) / (65536 + e));
      r.idx = 4'd0;
      r.prob = p > 65535 ? 16'hFFFF : p[15:0];
      r.last = 1'b1;
      pending_probs.push_back(r);
    end
  endfunction

  function automatic int draw_gap();
    if ($urandom_range(0, 15) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  // present one item, hold it until the transfer, then update the model
  task automatic send_item(row_t it, int gap);
    prob_t r;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= it.fn;
    layer_sel  <= it.lay;
    neuron_sel <= it.neu;
    source_sel <= it.src;
    value      <= it.val;
    do @(posedge clk); while (in_ready !== 1'b1);
    case (it.fn)
      mlp_pkg::FUNC_WEIGHT: weights[it.lay][it.neu][it.src] = it.val;
      mlp_pkg::FUNC_BIAS:   biases[it.lay][it.neu] = it.val;
      mlp_pkg::FUNC_INPUT:  inputs[it.neu] = it.val;
      default: begin
        if (it.prob >= 0) begin
          r.idx = 4'd0;
          r.prob = it.prob[15:0];
          r.last = 1'b1;
          pending_probs.push_back(r);
        end else predict_probabilities();
      end
    endcase
  endtask

  // wait for every result, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_probs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(logic [4:0] vals [6], bit stray);
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data  <= vals[i];
      @(posedge clk);
      regs[i] = (i == mlp_pkg::REG_LAYER_COUNT) ? {2'b0, vals[i][2:0]} : vals[i];
    end
    if (stray) begin
      // unmapped indexes must leave every register alone
      cfg_we    <= 1'b1;
      cfg_index <= 3'($urandom_range(6, 7));
      cfg_data  <= 5'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic row_t mk(logic [1:0] fn, int lay, int neu,
                              int src, logic [15:0] val, int prob);
    row_t t;
    t.fn = fn; t.lay = 2'(lay); t.neu = 4'(neu); t.src = 4'(src);
    t.val = val; t.prob = prob;
    return t;
  endfunction

  function automatic logic [15:0] rand_value();
    return ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 1023) - 512) : 16'($urandom);
  endfunction

  // accept results with random stalls and check them in order
  initial begin : result_sink
    int stall;
    prob_t want;
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_probs.size() == 0) begin
        $display("%0t: unexpected result idx %0d prob %0d last %0b",
                 $time, out_index, probability, last);
        fails++;
      end else begin
        want = pending_probs.pop_front();
        if (out_index !== want.idx) begin
          $display("%0t: out_index expected %0d actual %0d", $time, want.idx, out_index);
          fails++;
        end
        if (probability !== want.prob) begin
          $display("%0t: probability expected %0d actual %0d", $time, want.prob, probability);
          fails++;
        end
        if (last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, last);
          fails++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [63:0] v, e;
    logic [4:0] vals [6];
    row_t it;
    int runs;
    v = 64'h1_0000_0000;
    for (int k = 0; k < mlp_pkg::EXP_DEPTH; k++) begin
      e = (v + 64'd32768) >> 16;
      exp_lut[k] = (e > 64'd65535) ? 65535 : longint'(e);
      v = (v * mlp_pkg::EXP_STEP_Q32) >> 32;
    end
    regs[0] = 5'd1; regs[1] = 5'd16; regs[2] = 5'd16; regs[3] = 5'd16; regs[4] = 5'd16;
    regs[5] = 5'd1;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // clear every store so no run reads an unwritten entry
    for (int l = 0; l < mlp_pkg::MAX_LAYERS; l++)
      for (int j = 0; j < mlp_pkg::MAX_NEURONS; j++) begin
        send_item(mk(mlp_pkg::FUNC_BIAS, l, j, 0, 16'h0, -1), 0);
        for (int s = 0; s < mlp_pkg::MAX_NEURONS; s++)
          send_item(mk(mlp_pkg::FUNC_WEIGHT, l, j, s, 16'h0, -1), 0);
      end
    for (int s = 0; s < mlp_pkg::MAX_NEURONS; s++)
      send_item(mk(mlp_pkg::FUNC_INPUT, 0, s, 0, 16'h0, -1), 0);

    // directed rows at reset geometry: one layer, sixteen inputs, sigmoid output
    rows.push_back(mk(mlp_pkg::FUNC_RUN,    0, 0,  0,  16'h0000, 32768));
    rows.push_back(mk(mlp_pkg::FUNC_BIAS,   0, 0,  0,  16'h7FFF, -1));
    rows.push_back(mk(mlp_pkg::FUNC_RUN,    0, 0,  0,  16'h0000, 65535));
    rows.push_back(mk(mlp_pkg::FUNC_BIAS,   0, 0,  0,  16'h8000, -1));
    rows.push_back(mk(mlp_pkg::FUNC_RUN,    3, 15, 15, 16'hFFFF, 0));
    rows.push_back(mk(mlp_pkg::FUNC_BIAS,   0, 0,  0,  16'h0000, -1));
    rows.push_back(mk(mlp_pkg::FUNC_INPUT,  0, 0,  0,  16'h7FFF, -1));
    rows.push_back(mk(mlp_pkg::FUNC_WEIGHT, 0, 0,  0,  16'h7FFF, -1));
    rows.push_back(mk(mlp_pkg::FUNC_RUN,    0, 0,  0,  16'h0000, -1));
    rows.push_back(mk(mlp_pkg::FUNC_INPUT,  0, 0,  0,  16'h8000, -1));
    rows.push_back(mk(mlp_pkg::FUNC_RUN,    2, 5,  9,  16'h5555, -1));
    rows.push_back(mk(mlp_pkg::FUNC_WEIGHT, 0, 0,  0,  16'h8000, -1));
    rows.push_back(mk(mlp_pkg::FUNC_RUN,    1, 10, 6,  16'hAAAA, -1));
    rows.push_back(mk(mlp_pkg::FUNC_INPUT,  0, 15, 0,  16'h0180, -1));
    rows.push_back(mk(mlp_pkg::FUNC_WEIGHT, 0, 0,  15, 16'hFF00, -1));
    rows.push_back(mk(mlp_pkg::FUNC_WEIGHT, 3, 15, 15, 16'h0100, -1));
    rows.push_back(mk(mlp_pkg::FUNC_BIAS,   3, 15, 0,  16'hFFFF, -1));
    rows.push_back(mk(mlp_pkg::FUNC_RUN,    0, 0,  0,  16'h0000, -1));
    foreach (rows[i]) send_item(rows[i], draw_gap());

    // random phases: extremes first, then random geometry
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      for (int i = 0; i < 6; i++) begin
        if (ph == 0) vals[i] = 5'd31;
        else if (ph == 1) vals[i] = 5'd0;
        else if ($urandom_range(0, 5) == 0) vals[i] = 5'($urandom);
        else vals[i] = (i == mlp_pkg::REG_LAYER_COUNT) ? 5'($urandom_range(1, 4))
                                                       : 5'($urandom_range(1, 6));
      end
      write_regs(vals, ph >= 2);
      runs = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain();
        it.fn  = ($urandom_range(0, 6) == 0) ? mlp_pkg::FUNC_RUN : 2'($urandom_range(0, 2));
        it.lay = 2'($urandom);
        it.neu = 4'($urandom);
        it.src = 4'($urandom);
        it.val = rand_value();
        it.prob = -1;
        // keep loads within the active geometry most of the time
        if ($urandom_range(0, 3) != 0) begin
          it.lay = 2'($urandom_range(0, clamp_count({2'b0, regs[0][2:0]}, 4) - 1));
          it.neu = 4'($urandom_range(0, 5));
          it.src = 4'($urandom_range(0, 5));
        end
        if (it.fn == mlp_pkg::FUNC_RUN) runs++;
        if (n == PHASE_ITEMS - 1 && runs == 0) it.fn = mlp_pkg::FUNC_RUN;
        send_item(it, draw_gap());
      end
    end

    drain();
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
